FILE: sv/mpmt_pkg.sv
// ----------------------------------------------------------------------------
// mpmt_pkg
// Shared types and constants for the mobile prefix map table.
// ----------------------------------------------------------------------------
package mpmt_pkg;

   localparam int ENTRIES_DEFAULT = 64;
   localparam int HALF_W          = 64;
   localparam int STATUS_W        = 3;

   // Operation codes carried in the request word.
   localparam logic OP_INSERT = 1'b0;
   localparam logic OP_LOOKUP = 1'b1;

   typedef enum logic [STATUS_W-1:0] {
      ST_UPDATED  = 3'd0,
      ST_INSERTED = 3'd1,
      ST_FULL     = 3'd2,
      ST_FOUND    = 3'd3,
      ST_NOTFOUND = 3'd4
   } status_type;

endpackage

FILE: sv/mpmt_req_if.sv
// ----------------------------------------------------------------------------
// mpmt_req_if
// Request channel: one operation with its key and, for inserts, its prefix.
// ----------------------------------------------------------------------------
interface mpmt_req_if;
   import mpmt_pkg::*;

   logic              valid;
   logic              ready;
   logic              operation;
   logic [HALF_W-1:0] key_high;
   logic [HALF_W-1:0] key_low;
   logic [HALF_W-1:0] new_prefix_high;
   logic [HALF_W-1:0] new_prefix_low;

   modport source (output valid, operation, key_high, key_low, new_prefix_high,
                   new_prefix_low, input ready);
   modport sink   (input valid, operation, key_high, key_low, new_prefix_high,
                   new_prefix_low, output ready);
endinterface

FILE: sv/mpmt_rsp_if.sv
// ----------------------------------------------------------------------------
// mpmt_rsp_if
// Response channel: a status code and the prefix found by a lookup.
// ----------------------------------------------------------------------------
interface mpmt_rsp_if;
   import mpmt_pkg::*;

   logic                valid;
   logic                ready;
   logic [STATUS_W-1:0] status;
   logic [HALF_W-1:0]   found_prefix_high;
   logic [HALF_W-1:0]   found_prefix_low;

   modport source (output valid, status, found_prefix_high, found_prefix_low,
                   input ready);
   modport sink   (input valid, status, found_prefix_high, found_prefix_low,
                   output ready);
endinterface

FILE: sv/mobile_prefix_map_table.sv
// One item at a time: a request is taken only while idle, the linear key scan
// sets the pace, and the next request word can be taken once the response is
// loaded; a busy response channel holds the item in its final state. Reset:
// synchronous, active high; it empties the table (fill count zero) and clears
// the control state other than the compare and slot indices, but not the memories.
// ----------------------------------------------------------------------------
// mobile_prefix_map_table
// Exact-match table from a 128-bit node identifier to a 128-bit home prefix.
// ----------------------------------------------------------------------------
module mobile_prefix_map_table #(
   parameter int ENTRIES = mpmt_pkg::ENTRIES_DEFAULT
) (
   input logic       clock,
   input logic       reset,
   mpmt_req_if.sink   req_if,
   mpmt_rsp_if.source rsp_if
);
   import mpmt_pkg::*;

   localparam int AW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int CW = $clog2(ENTRIES + 1);
   localparam int KW = 2 * HALF_W;
   localparam logic [CW-1:0] ENTRIES_C = CW'(ENTRIES);

   typedef enum logic [2:0] {
      S_IDLE = 3'b001,
      S_SCAN = 3'b010,
      S_DONE = 3'b100
   } state_type;

   // Control state.
   state_type     state_ff, state_in;
   logic [CW-1:0] filled_ff, filled_in;
   logic [CW-1:0] idx_ff, idx_in;
   logic          chk_valid_ff, chk_valid_in;
   logic [AW-1:0] chk_idx_ff, chk_idx_in;
   logic          hit_ff, hit_in;
   logic [AW-1:0] slot_ff, slot_in;
   logic          rsp_valid_ff, rsp_valid_in;

   // Payload registers.
   logic          op_ff, op_in;
   logic [KW-1:0] key_ff, key_in;
   logic [KW-1:0] prefix_ff, prefix_in;
   logic [KW-1:0] found_ff, found_in;
   status_type    rsp_status_ff, rsp_status_in;
   logic [KW-1:0] rsp_prefix_ff, rsp_prefix_in;

   // Memory ports.
   logic [KW-1:0] key_rd, prefix_rd;
   logic          key_we, prefix_we;
   logic [AW-1:0] wr_addr, rd_addr;

   logic accept, issue, match, out_free, done_go, room;

   assign accept   = req_if.valid && req_if.ready;
   assign out_free = !rsp_valid_ff || rsp_if.ready;
   assign done_go  = (state_ff == S_DONE) && out_free;
   assign room     = filled_ff < ENTRIES_C;

   // The scan is pipelined one deep: the read for entry idx goes out while the
   // key read on the previous cycle (entry chk_idx) is compared.
   assign issue   = idx_ff < filled_ff;
   assign rd_addr = idx_ff[AW-1:0];
   assign match   = chk_valid_ff && (key_rd == key_ff);

   // Writes happen only in the final state, so a scan never sees a write
   // to the same entry in flight.
   assign key_we    = done_go && (op_ff == OP_INSERT) && !hit_ff && room;
   assign prefix_we = done_go && (op_ff == OP_INSERT) && (hit_ff || room);
   assign wr_addr   = hit_ff ? slot_ff : filled_ff[AW-1:0];

   mpmt_ram #(.WIDTH(KW), .DEPTH(ENTRIES)) u_key_ram (
      .clock   (clock),
      .wr_en   (key_we),
      .wr_addr (wr_addr),
      .wr_data (key_ff),
      .rd_addr (rd_addr),
      .rd_data (key_rd)
   );

   mpmt_ram #(.WIDTH(KW), .DEPTH(ENTRIES)) u_prefix_ram (
      .clock   (clock),
      .wr_en   (prefix_we),
      .wr_addr (wr_addr),
      .wr_data (prefix_ff),
      .rd_addr (rd_addr),
      .rd_data (prefix_rd)
   );

   always_comb begin
      state_in      = state_ff;
      filled_in     = filled_ff;
      idx_in        = idx_ff;
      chk_valid_in  = chk_valid_ff;
      chk_idx_in    = chk_idx_ff;
      hit_in        = hit_ff;
      slot_in       = slot_ff;
      rsp_valid_in  = rsp_valid_ff;
      op_in         = op_ff;
      key_in        = key_ff;
      prefix_in     = prefix_ff;
      found_in      = found_ff;
      rsp_status_in = rsp_status_ff;
      rsp_prefix_in = rsp_prefix_ff;

      if (rsp_valid_ff && rsp_if.ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               op_in        = req_if.operation;
               key_in       = {req_if.key_high, req_if.key_low};
               prefix_in    = {req_if.new_prefix_high, req_if.new_prefix_low};
               idx_in       = '0;
               chk_valid_in = 1'b0;
               state_in     = S_SCAN;
            end
         end
         S_SCAN: begin
            if (match) begin
               // A hit ends the scan early; the prefix read alongside the
               // key belongs to the same entry.
               hit_in   = 1'b1;
               slot_in  = chk_idx_ff;
               found_in = prefix_rd;
               state_in = S_DONE;
            end else if (issue) begin
               chk_valid_in = 1'b1;
               chk_idx_in   = idx_ff[AW-1:0];
               idx_in       = idx_ff + 1'b1;
            end else begin
               hit_in   = 1'b0;
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_prefix_in = '0;
               if (op_ff == OP_INSERT) begin
                  if (hit_ff) begin
                     rsp_status_in = ST_UPDATED;
                  end else if (room) begin
                     rsp_status_in = ST_INSERTED;
                     filled_in     = filled_ff + 1'b1;
                  end else begin
                     rsp_status_in = ST_FULL;
                  end
               end else if (hit_ff) begin
                  rsp_status_in = ST_FOUND;
                  rsp_prefix_in = found_ff;
               end else begin
                  rsp_status_in = ST_NOTFOUND;
               end
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         filled_ff    <= '0;
         idx_ff       <= '0;
         chk_valid_ff <= 1'b0;
         hit_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         filled_ff    <= filled_in;
         idx_ff       <= idx_in;
         chk_valid_ff <= chk_valid_in;
         hit_ff       <= hit_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      chk_idx_ff    <= chk_idx_in;
      slot_ff       <= slot_in;
      op_ff         <= op_in;
      key_ff        <= key_in;
      prefix_ff     <= prefix_in;
      found_ff      <= found_in;
      rsp_status_ff <= rsp_status_in;
      rsp_prefix_ff <= rsp_prefix_in;
   end

   assign req_if.ready             = (state_ff == S_IDLE);
   assign rsp_if.valid             = rsp_valid_ff;
   assign rsp_if.status            = rsp_status_ff;
   assign rsp_if.found_prefix_high = rsp_prefix_ff[KW-1:HALF_W];
   assign rsp_if.found_prefix_low  = rsp_prefix_ff[HALF_W-1:0];

   // The fill count never passes the table size.
   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      filled_ff <= ENTRIES_C)
      else $error("fill count exceeds table size");

   // An entry under comparison always lies inside the filled region.
   a_chk_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SCAN) && chk_valid_ff |-> CW'(chk_idx_ff) < filled_ff)
      else $error("scan compares an unfilled entry");

   // The fill count grows only together with an inserted-new response.
   a_fill_grows: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) && (filled_ff != $past(filled_ff)) |->
         rsp_valid_ff && (rsp_status_ff == ST_INSERTED))
      else $error("fill count changed without an insert");

   // Only a lookup hit carries a nonzero prefix.
   a_prefix_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && (rsp_status_ff != ST_FOUND) |-> rsp_prefix_ff == '0)
      else $error("nonzero prefix on a response that is not a lookup hit");

   // A key write is always an append at the current end of the table.
   a_append_only: assert property (@(posedge clock) disable iff (reset)
      key_we |-> !hit_ff && room && (wr_addr == filled_ff[AW-1:0]))
      else $error("key written away from the table end");
endmodule

FILE: sv/mpmt_ram.sv
// ----------------------------------------------------------------------------
// mpmt_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
module mpmt_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 64
) (
   input  logic                                   clock,
   input  logic                                   wr_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                       wr_data,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                       rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule
